// ----- sv/near_clip_vertex_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// Near clip vertex interpolator assertion macros
// Concurrent check wrappers; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef NEAR_CLIP_VERTEX_INTERPOLATOR_MACROS_SVH
`define NEAR_CLIP_VERTEX_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define NCVI_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ncvi check failed");
// consequent must hold at the edge after the antecedent
`define NCVI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncvi sequence check failed");
`else
`define NCVI_ASSERT(label, cond)
`define NCVI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/ncvi_pkg.sv -----
// ----------------------------------------------------------------------------
// Near clip vertex interpolator package
// Shared widths, Q31 constants and the request/status types of the serial units.
// ----------------------------------------------------------------------------
package ncvi_pkg;

    localparam int WORD_W    = 32;
    localparam int Q31_SHIFT = 31;
    localparam int DIV_STEPS = Q31_SHIFT;
    localparam int MUL_STEPS = WORD_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    localparam logic [WORD_W-1:0] FACTOR_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] FACTOR_MIN = 32'h8000_0000;

    localparam logic KIND_DEPTH = 1'b0;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] num;
        logic signed [WORD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     start;
        logic signed [WORD_W-1:0] diff;
        logic signed [WORD_W-1:0] factor;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- sv/near_clip_vertex_interpolator.sv -----
// ----------------------------------------------------------------------------
// Near clip vertex interpolator
// Clips one attribute pair per word against the near plane in Q31.
//
//  channel   dir  bits  contents
//  s_axis    in   64    tdata: start_value, end_value; tuser: kind
//  m_axis    out  32    tdata: clipped_value
//  cfg       in   32    near_plane_depth, write enable only
//
//  An attribute word goes straight to the serial multiplier; a depth word
//  first gets its factor, clamped to full scale or taken from the serial
//  divider, and then goes to the multiplier. The divider runs 31 steps and
//  the multiplier 32 steps; start_value plus the product goes to the output.
//  One word is in flight; s_axis_tready rises again once the result is loaded.
//  A finished result waits in the output register while the next word is taken.
//  Reset is synchronous, active low; factor and plane depth reset to zero.
// ----------------------------------------------------------------------------
`include "near_clip_vertex_interpolator_macros.svh"

module near_clip_vertex_interpolator
    import ncvi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] start_value, [63:32] end_value
    input  logic [0:0]  s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] clipped_value
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACTOR,
        ST_DIV,
        ST_MUL,
        ST_WRITE
    } t_state;

    t_state                   r_state;
    logic signed [WORD_W-1:0] r_near;
    logic signed [WORD_W-1:0] r_factor;
    logic signed [WORD_W-1:0] r_start;
    logic signed [WORD_W-1:0] r_diff;
    logic signed [WORD_W-1:0] r_num;
    logic                     r_div_start;
    logic                     r_mul_start;
    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out;

    logic                     w_in_acc;
    logic                     w_slot_free;
    logic signed [WORD_W-1:0] w_neg_den;
    logic                     w_clamp_hi;
    logic                     w_clamp_lo;
    t_div_req                 w_div_req;
    t_mul_req                 w_mul_req;
    t_unit_sts                w_div_sts;
    t_unit_sts                w_mul_sts;
    logic [WORD_W-1:0]        w_div_q;
    logic [WORD_W-1:0]        w_mul_res;

    assign s_axis_tready = (r_state == ST_IDLE) && !w_div_sts.busy && !w_mul_sts.busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    // den is end - start, already held in r_diff
    assign w_neg_den  = WORD_W'(0) - r_diff;
    assign w_clamp_hi = (r_num >= r_diff);
    assign w_clamp_lo = (r_num <= w_neg_den);

    assign w_div_req.start = r_div_start;
    assign w_div_req.num   = r_num;
    assign w_div_req.den   = r_diff;

    assign w_mul_req.start  = r_mul_start;
    assign w_mul_req.diff   = r_diff;
    assign w_mul_req.factor = r_factor;

    ncvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_sts   (w_div_sts),
        .o_quot  (w_div_q)
    );

    ncvi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_sts   (w_mul_sts),
        .o_prod  (w_mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= '0;
        end else if (i_cfg_we) begin
            r_near <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_factor    <= '0;
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser[0] == KIND_DEPTH) begin
                            r_state <= ST_FACTOR;
                        end else begin
                            r_mul_start <= 1'b1;
                            r_state     <= ST_MUL;
                        end
                    end
                end
                ST_FACTOR: begin
                    if (w_clamp_hi) begin
                        r_factor    <= FACTOR_MAX;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_MUL;
                    end else if (w_clamp_lo) begin
                        r_factor    <= FACTOR_MIN;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_MUL;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_sts.done) begin
                        r_factor    <= w_div_q;
                        r_mul_start <= 1'b1;
                        r_state     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (w_mul_sts.done) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    // hold until the output register can take the word
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_start <= s_axis_tdata[31:0];
            r_diff  <= s_axis_tdata[63:32] - s_axis_tdata[31:0];
            r_num   <= r_near - s_axis_tdata[31:0];
        end
        if (r_state == ST_WRITE && w_slot_free) begin
            r_out <= r_start + w_mul_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `NCVI_ASSERT(a_div_done_in_div, !w_div_sts.done || r_state == ST_DIV)
    `NCVI_ASSERT(a_mul_done_in_mul, !w_mul_sts.done || r_state == ST_MUL)
    `NCVI_ASSERT(a_div_quot_range, !w_div_sts.done || w_div_q != FACTOR_MIN)
    `NCVI_ASSERT_NEXT(a_attr_starts_mul, w_in_acc && s_axis_tuser[0] != KIND_DEPTH, r_mul_start)

endmodule

// ----- sv/ncvi_div.sv -----
// ----------------------------------------------------------------------------
// Q31 factor divider
// Restoring divider, one quotient bit per cycle: (|num| << 31) / den, signed.
// ----------------------------------------------------------------------------
module ncvi_div
    import ncvi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output t_unit_sts         o_sts,
    output logic [WORD_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_neg;
    logic [WORD_W-2:0]    r_den;
    logic [WORD_W-2:0]    r_rem;
    logic [DIV_STEPS-1:0] r_q;

    logic [WORD_W-1:0]    w_num_abs;
    logic [WORD_W-1:0]    w_shift;
    logic [WORD_W:0]      w_trial;
    logic                 w_ge;

    // |num| < den, so the magnitude always fits below the sign bit
    assign w_num_abs = i_req.num[WORD_W-1] ? (WORD_W'(0) - i_req.num) : i_req.num;
    assign w_shift   = {r_rem, 1'b0};
    assign w_trial   = {1'b0, w_shift} - {2'b00, r_den};
    assign w_ge      = !w_trial[WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_neg <= i_req.num[WORD_W-1];
            r_den <= i_req.den[WORD_W-2:0];
            r_rem <= w_num_abs[WORD_W-2:0];
            r_q   <= '0;
        end else if (r_busy) begin
            // remainder stays below den, so it never needs the top bit
            r_rem <= w_ge ? w_trial[WORD_W-2:0] : w_shift[WORD_W-2:0];
            r_q   <= {r_q[DIV_STEPS-2:0], w_ge};
        end
    end

    // truncate toward zero: negate the magnitude quotient
    assign o_quot    = r_neg ? (WORD_W'(0) - {1'b0, r_q}) : {1'b0, r_q};
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ----- sv/ncvi_mul.sv -----
// ----------------------------------------------------------------------------
// Serial Q31 multiplier
// Shift-add over the factor one bit per cycle; returns (diff * factor) >> 31.
// ----------------------------------------------------------------------------
module ncvi_mul
    import ncvi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mul_req          i_req,
    output t_unit_sts         o_sts,
    output logic [WORD_W-1:0] o_prod
);

    localparam int ACC_W = WORD_W + 2;

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] r_hi;
    logic [WORD_W-1:0]       r_lo;
    logic signed [ACC_W-1:0] r_mcand;

    logic signed [ACC_W-1:0] w_addend;
    logic signed [ACC_W-1:0] w_sum;

    // the factor's sign bit carries weight -2^31: subtract on the last step
    always_comb begin
        w_addend = '0;
        if (r_lo[0]) begin
            w_addend = (r_cnt == '0) ? -r_mcand : r_mcand;
        end
        w_sum = r_hi + w_addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MUL_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_hi    <= '0;
            r_lo    <= i_req.factor;
            r_mcand <= ACC_W'(i_req.diff);
        end else if (r_busy) begin
            // shift the partial product right, low bits fill in from the top
            r_hi <= {w_sum[ACC_W-1], w_sum[ACC_W-1:1]};
            r_lo <= {w_sum[0], r_lo[WORD_W-1:1]};
        end
    end

    assign o_prod     = {r_hi[WORD_W-2:0], r_lo[WORD_W-1]};
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule
